### design/tcp_sender_window_retransmit_macros.svh
// ----------------------------------------------------------------------------
// TCP sender assertion macros
// Shared assertion forms for the TCP sender window block and its checker.
// ----------------------------------------------------------------------------
`ifndef TCP_SENDER_WINDOW_RETRANSMIT_MACROS_SVH
`define TCP_SENDER_WINDOW_RETRANSMIT_MACROS_SVH

// Assertion sampled on clk and disabled while rst is high.
`define TSW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion sampled on clk that also holds during reset.
`define TSW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/tsw_pkg.sv
// ----------------------------------------------------------------------------
// TCP sender package
// Constants, codes and the descriptor type shared by the TCP sender block.
// ----------------------------------------------------------------------------
package tsw_pkg;

  localparam int MAX_PAYLOAD = 1000;
  localparam int PLEN_W = 10;
  localparam int SEQ_W = 64;
  localparam int MAX_RESULTS = 64;
  localparam int RES_CNT_W = 7;
  localparam int QUEUE_DEPTH = 64;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [63:0] HALF_RANGE = 64'h0000_0000_8000_0000;

  localparam logic [1:0] MODE_FILL = 2'd0;
  localparam logic [1:0] MODE_ACK = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;
  localparam logic [1:0] MODE_EMPTY = 2'd3;

  localparam logic [1:0] KIND_NEW = 2'd0;
  localparam logic [1:0] KIND_RETX = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_ISEQ = 1'b1;

  typedef struct packed {
    logic [SEQ_W-1:0] start;
    logic [PLEN_W-1:0] plen;
    logic syn;
    logic fin;
  } desc_t;

endpackage

### design/tsw_desc_mem.sv
// ----------------------------------------------------------------------------
// TCP sender descriptor memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tsw_desc_mem #(
  parameter int DEPTH = tsw_pkg::QUEUE_DEPTH,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic clk,
  input  logic wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  tsw_pkg::desc_t wr_data,
  input  logic rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output tsw_pkg::desc_t rd_data
);

  tsw_pkg::desc_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/tcp_sender_window_retransmit.sv
// ----------------------------------------------------------------------------
// TCP sender window and retransmission control
// Descriptor-level TCP sender: fill, ack, tick and empty-segment words in,
// segment descriptors and status words out.
// ----------------------------------------------------------------------------
// Channel   Handshake            Payload
// in        in_valid/in_ready    mode ack_number window_advert elapsed_ms ...
// out       out_valid/out_ready  kind seq_wrapped syn_flag fin_flag ... last
// cfg       cfg_write            cfg_index cfg_data
//
// One word is processed at a time. A fill emits one new-segment descriptor per
// segment that it sends, and an ack that advances pops acknowledged descriptors
// one at a time through the descriptor memory port.
// Output stalls hold the sequencer. Reset is immediate with no clearing pass.
// ----------------------------------------------------------------------------
module tcp_sender_window_retransmit #(
  parameter int QUEUE_DEPTH = tsw_pkg::QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic cfg_index,
  input  logic [31:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] mode,
  input  logic [31:0] ack_number,
  input  logic [15:0] window_advert,
  input  logic [31:0] elapsed_ms,
  input  logic [15:0] stream_buffered,
  input  logic stream_ended,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] kind,
  output logic [31:0] seq_wrapped,
  output logic syn_flag,
  output logic fin_flag,
  output logic [9:0] payload_len,
  output logic last,
  output logic [16:0] in_flight,
  output logic [4:0] retx_count
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int PW = tsw_pkg::PLEN_W;
  localparam int SW = tsw_pkg::SEQ_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_STATUS, S_EMIT, S_TICK2, S_FILL2, S_FILL_SEG,
    S_ACK2, S_ACK3, S_ACK4, S_POP_RD, S_POP_CHK
  } state_t;

  state_t state;

  logic [15:0] init_timeout;
  logic [31:0] init_seq;

  logic [1:0] in_mode;
  logic [31:0] in_ack;
  logic [15:0] in_adv;
  logic [31:0] in_elapsed;
  logic [15:0] in_buf;
  logic in_end;

  logic [SW-1:0] next_abs;
  logic [SW-1:0] acked_abs;
  logic [15:0] window;
  logic [31:0] timer;
  logic [31:0] timeout;
  logic [4:0] retx;
  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic fin_done;

  logic [SW-1:0] work;
  logic ack_sub;
  logic ack_add;
  logic [15:0] fill_pay;
  logic fill_flag;
  logic [tsw_pkg::RES_CNT_W-1:0] res_cnt;

  logic [1:0] pend_kind;
  logic [31:0] pend_seq;
  logic pend_syn;
  logic pend_fin;
  logic [PW-1:0] pend_plen;
  logic pend_last;

  tsw_pkg::desc_t wr_data;
  tsw_pkg::desc_t rd_data;
  logic wr_en;
  logic rd_en;
  logic [IDX_W-1:0] tail;
  logic [SUM_W-1:0] tail_sum;
  logic [IDX_W-1:0] head_inc;
  logic q_full;
  logic can_load;
  logic [SW-1:0] infl_diff;
  logic [16:0] infl_sat;
  logic [32:0] timer_sum;
  logic [PW-1:0] seg_len;
  logic seg_fin;
  logic [15:0] pay_rem;
  logic flag_rem;
  logic [tsw_pkg::RES_CNT_W-1:0] res_cnt_inc;
  logic seg_more;
  logic [15:0] infl16;
  logic infl_over;
  logic [15:0] room;
  logic [15:0] pay0;
  logic flag0;
  logic [15:0] pay_w;
  logic flag_w;
  logic [SW-1:0] d_up;
  logic [SW-1:0] d_dn;
  logic [SW-1:0] ack_diff;
  logic [15:0] ack_nw;
  logic [SW-1:0] desc_end;

  always_comb begin
    tail_sum = SUM_W'(head) + SUM_W'(count);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
    end
    tail = tail_sum[IDX_W-1:0];
    head_inc = (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + IDX_W'(1);
    q_full = (count == CNT_W'(QUEUE_DEPTH));
    can_load = !out_valid || out_ready;
    infl_diff = next_abs - acked_abs;
    infl_sat = (|infl_diff[SW-1:17]) ? 17'h1FFFF : infl_diff[16:0];
    timer_sum = {1'b0, timer} + {1'b0, in_elapsed};
  end

  always_comb begin
    if (fill_pay > 16'(tsw_pkg::MAX_PAYLOAD)) begin
      seg_len = PW'(tsw_pkg::MAX_PAYLOAD);
      seg_fin = 1'b0;
    end else begin
      seg_len = fill_pay[PW-1:0];
      seg_fin = fill_flag;
    end
    pay_rem = fill_pay - 16'(seg_len);
    flag_rem = fill_flag && !seg_fin;
    res_cnt_inc = res_cnt + tsw_pkg::RES_CNT_W'(1);
    seg_more = (pay_rem != '0 || flag_rem) && (count < CNT_W'(QUEUE_DEPTH - 1)) &&
               (res_cnt_inc < tsw_pkg::RES_CNT_W'(tsw_pkg::MAX_RESULTS));
  end

  always_comb begin
    infl16 = work[15:0];
    infl_over = (|work[SW-1:16]) || (infl16 > window) ||
                (infl16 == window && window != '0);
    room = window - infl16;
    pay0 = (in_buf < room) ? in_buf : room;
    flag0 = in_end && (pay0 < room);
    pay_w = pay0;
    flag_w = flag0;
    if (window == '0) begin
      if (in_buf != '0) begin
        pay_w = 16'd1;
        flag_w = 1'b0;
      end else if (in_end) begin
        pay_w = '0;
        flag_w = 1'b1;
      end
    end
  end

  always_comb begin
    d_up = work - acked_abs;
    d_dn = acked_abs - work;
    ack_diff = acked_abs - work;
    ack_nw = ({48'b0, in_adv} <= ack_diff) ? '0 : in_adv - ack_diff[15:0];
    desc_end = rd_data.start + SW'(rd_data.plen) + SW'(rd_data.syn) + SW'(rd_data.fin);
  end

  always_comb begin
    wr_en = 1'b0;
    wr_data.start = next_abs;
    wr_data.plen = seg_len;
    wr_data.syn = 1'b0;
    wr_data.fin = seg_fin;
    if (state == S_DECODE && in_mode == tsw_pkg::MODE_FILL && next_abs == '0 && !q_full) begin
      wr_en = 1'b1;
      wr_data.plen = '0;
      wr_data.syn = 1'b1;
      wr_data.fin = 1'b0;
    end else if (state == S_FILL_SEG) begin
      wr_en = 1'b1;
    end
    rd_en = (state == S_DECODE && in_mode == tsw_pkg::MODE_TICK) || (state == S_POP_RD);
  end

  tsw_desc_mem #(
    .DEPTH(QUEUE_DEPTH),
    .IDX_W(IDX_W)
  ) u_mem (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(tail),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(head),
    .rd_data(rd_data)
  );

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      init_timeout <= tsw_pkg::TIMEOUT_RESET;
      init_seq <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tsw_pkg::CFG_TIMEOUT: init_timeout <= cfg_data[15:0];
        tsw_pkg::CFG_ISEQ: init_seq <= cfg_data;
        default: init_seq <= init_seq;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      next_abs <= '0;
      acked_abs <= '0;
      window <= 16'd1;
      timer <= '0;
      timeout <= 32'(tsw_pkg::TIMEOUT_RESET);
      retx <= '0;
      head <= '0;
      count <= '0;
      fin_done <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            in_mode <= mode;
            in_ack <= ack_number;
            in_adv <= window_advert;
            in_elapsed <= elapsed_ms;
            in_buf <= stream_buffered;
            in_end <= stream_ended;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_cnt <= '0;
          unique case (in_mode)
            tsw_pkg::MODE_FILL: begin
              if (next_abs == '0) begin
                if (q_full) begin
                  state <= S_STATUS;
                end else begin
                  if (count == '0) begin
                    timer <= '0;
                    timeout <= 32'(init_timeout);
                    retx <= '0;
                  end
                  count <= count + CNT_W'(1);
                  next_abs <= next_abs + SW'(1);
                  pend_kind <= tsw_pkg::KIND_NEW;
                  pend_seq <= '0;
                  pend_syn <= 1'b1;
                  pend_fin <= 1'b0;
                  pend_plen <= '0;
                  pend_last <= 1'b1;
                  state <= S_EMIT;
                end
              end else if (fin_done) begin
                state <= S_STATUS;
              end else begin
                work <= infl_diff;
                state <= S_FILL2;
              end
            end
            tsw_pkg::MODE_ACK: begin
              work <= {acked_abs[SW-1:32], in_ack - init_seq};
              state <= S_ACK2;
            end
            tsw_pkg::MODE_TICK: begin
              if (count == '0) begin
                state <= S_STATUS;
              end else begin
                timer <= timer_sum[32] ? 32'hFFFF_FFFF : timer_sum[31:0];
                state <= S_TICK2;
              end
            end
            tsw_pkg::MODE_EMPTY: begin
              pend_kind <= tsw_pkg::KIND_EMPTY;
              pend_seq <= next_abs[31:0];
              pend_syn <= 1'b0;
              pend_fin <= 1'b0;
              pend_plen <= '0;
              pend_last <= 1'b1;
              state <= S_EMIT;
            end
            default: state <= S_STATUS;
          endcase
        end
        S_STATUS: begin
          pend_kind <= tsw_pkg::KIND_STATUS;
          pend_seq <= next_abs[31:0];
          pend_syn <= 1'b0;
          pend_fin <= 1'b0;
          pend_plen <= '0;
          pend_last <= 1'b1;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (can_load) begin
            out_valid <= 1'b1;
            kind <= pend_kind;
            seq_wrapped <= pend_seq + init_seq;
            syn_flag <= pend_syn;
            fin_flag <= pend_fin;
            payload_len <= pend_plen;
            last <= pend_last;
            in_flight <= infl_sat;
            retx_count <= retx;
            state <= pend_last ? S_IDLE : S_FILL_SEG;
          end
        end
        S_TICK2: begin
          if (timer < timeout) begin
            state <= S_STATUS;
          end else begin
            if (window != '0) begin
              timeout <= timeout[31] ? 32'hFFFF_FFFF : {timeout[30:0], 1'b0};
              if (retx != 5'd31) begin
                retx <= retx + 5'd1;
              end
            end
            timer <= '0;
            pend_kind <= tsw_pkg::KIND_RETX;
            pend_seq <= rd_data.start[31:0];
            pend_syn <= rd_data.syn;
            pend_fin <= rd_data.fin;
            pend_plen <= rd_data.plen;
            pend_last <= 1'b1;
            state <= S_EMIT;
          end
        end
        S_FILL2: begin
          fill_pay <= pay_w;
          fill_flag <= flag_w;
          if (infl_over || (pay_w == '0 && !flag_w) || q_full) begin
            state <= S_STATUS;
          end else begin
            state <= S_FILL_SEG;
          end
        end
        S_FILL_SEG: begin
          if (count == '0) begin
            timer <= '0;
            timeout <= 32'(init_timeout);
            retx <= '0;
          end
          count <= count + CNT_W'(1);
          next_abs <= next_abs + SW'(seg_len) + SW'(seg_fin);
          if (seg_fin) begin
            fin_done <= 1'b1;
          end
          fill_pay <= pay_rem;
          fill_flag <= flag_rem;
          res_cnt <= res_cnt_inc;
          pend_kind <= tsw_pkg::KIND_NEW;
          pend_seq <= next_abs[31:0];
          pend_syn <= 1'b0;
          pend_fin <= seg_fin;
          pend_plen <= seg_len;
          pend_last <= !seg_more;
          state <= S_EMIT;
        end
        S_ACK2: begin
          ack_sub <= (work > acked_abs) && (d_up > tsw_pkg::HALF_RANGE) && (|work[SW-1:32]);
          ack_add <= (work < acked_abs) && (d_dn > tsw_pkg::HALF_RANGE);
          state <= S_ACK3;
        end
        S_ACK3: begin
          if (ack_sub) begin
            work[SW-1:32] <= work[SW-1:32] - 32'd1;
          end else if (ack_add) begin
            work[SW-1:32] <= work[SW-1:32] + 32'd1;
          end
          state <= S_ACK4;
        end
        S_ACK4: begin
          priority if (work > next_abs) begin
            state <= S_STATUS;
          end else if (acked_abs > work) begin
            if (ack_nw > window) begin
              window <= ack_nw;
            end
            state <= S_STATUS;
          end else if (acked_abs == work) begin
            if (in_adv > window) begin
              window <= in_adv;
            end
            state <= S_STATUS;
          end else begin
            acked_abs <= work;
            window <= in_adv;
            timer <= '0;
            timeout <= 32'(init_timeout);
            retx <= '0;
            state <= S_POP_RD;
          end
        end
        S_POP_RD: begin
          state <= (count == '0) ? S_STATUS : S_POP_CHK;
        end
        S_POP_CHK: begin
          if (acked_abs < desc_end) begin
            state <= S_STATUS;
          end else begin
            head <= head_inc;
            count <= count - CNT_W'(1);
            state <= S_POP_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/tsw_checker.sv
// ----------------------------------------------------------------------------
// TCP sender port checker
// Watches the ports of the TCP sender block and flags illegal sequences.
// ----------------------------------------------------------------------------
`include "tcp_sender_window_retransmit_macros.svh"

module tsw_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] kind,
  input logic syn_flag,
  input logic fin_flag,
  input logic [9:0] payload_len,
  input logic last
);

  `TSW_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(last), "Output word changed while stalled.")
  `TSW_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "Input taken while a word is in progress.")
  `TSW_ASSERT(a_no_seg_fields, out_valid && (kind == tsw_pkg::KIND_STATUS || kind == tsw_pkg::KIND_EMPTY) |-> !syn_flag && !fin_flag && payload_len == '0, "Status or empty word carries segment fields.")
  `TSW_ASSERT(a_multi_new, out_valid && !last |-> kind == tsw_pkg::KIND_NEW, "Only new segments may be followed by more words.")
  `TSW_ASSERT(a_plen_max, out_valid |-> payload_len <= 10'(tsw_pkg::MAX_PAYLOAD), "Payload length exceeds the maximum.")

endmodule

bind tcp_sender_window_retransmit tsw_checker u_tsw_checker (.*);
